FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/cbq_pkg.sv
// Types, constants and microcode for the cascaded biquad low-pass.
package cbq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int DELAY_BITS     = 40;
  localparam int FEED_W         = 31;
  localparam int COEF_W         = 32;
  localparam int CFG_IDX_W      = 2;

  // operand split into two halves for the shared multiplier
  localparam int HALF_BITS = DELAY_BITS / 2;
  localparam int MUL_A_W   = DELAY_BITS - HALF_BITS + 1;
  localparam int MUL_B_W   = COEF_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = DELAY_BITS + MUL_B_W + 3;
  localparam int RND_W     = ACC_W - COEF_FRAC_BITS;
  localparam int SUM_W     = RND_W + 1;

  localparam int SEC_STEPS   = 12;
  localparam int TOTAL_STEPS = 2 * SEC_STEPS;
  localparam int STEP_W      = $clog2(TOTAL_STEPS);
  localparam int LS_W        = $clog2(SEC_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_FEED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BACK1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BACK2 = CFG_IDX_W'(2);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;
  typedef enum logic [1:0] {CF_FEED, CF_FEED2, CF_BACK1, CF_BACK2} coef_sel_t;
  typedef enum logic [1:0] {FIN_Y, FIN_DA, FIN_DB} fin_t;

  typedef struct packed {
    logic      issue;
    logic      op_y;
    coef_sel_t coef_sel;
    logic      hi;
    logic      clr;
    logic      fin;
    fin_t      fin_tgt;
  } micro_t;

  typedef struct packed {
    micro_t u;
    logic   sec;
    logic   sec_end;
    logic   load_out;
  } ctrl_t;

  // One section: a0*x, then 2a0*x + b1*y, then a0*x + b2*y.
  // A sum is finished once its last product has passed the product and accumulator registers.
  function automatic micro_t decode(input logic [LS_W-1:0] ls);
    micro_t m;
    m = '{issue: 1'b0, op_y: 1'b0, coef_sel: CF_FEED, hi: 1'b0, clr: 1'b0,
          fin: 1'b0, fin_tgt: FIN_Y};
    case (ls)
      LS_W'(0):  begin m.issue = 1'b1; m.clr = 1'b1; end
      LS_W'(1):  begin m.issue = 1'b1; m.hi = 1'b1; end
      LS_W'(2):  begin m.issue = 1'b1; m.coef_sel = CF_FEED2; m.clr = 1'b1; end
      LS_W'(3):  begin
        m.issue = 1'b1; m.coef_sel = CF_FEED2; m.hi = 1'b1;
        m.fin = 1'b1; m.fin_tgt = FIN_Y;
      end
      LS_W'(4):  begin m.issue = 1'b1; m.op_y = 1'b1; m.coef_sel = CF_BACK1; end
      LS_W'(5):  begin
        m.issue = 1'b1; m.op_y = 1'b1; m.coef_sel = CF_BACK1; m.hi = 1'b1;
      end
      LS_W'(6):  begin m.issue = 1'b1; m.clr = 1'b1; end
      LS_W'(7):  begin
        m.issue = 1'b1; m.hi = 1'b1;
        m.fin = 1'b1; m.fin_tgt = FIN_DA;
      end
      LS_W'(8):  begin m.issue = 1'b1; m.op_y = 1'b1; m.coef_sel = CF_BACK2; end
      LS_W'(9):  begin
        m.issue = 1'b1; m.op_y = 1'b1; m.coef_sel = CF_BACK2; m.hi = 1'b1;
      end
      LS_W'(11): begin m.fin = 1'b1; m.fin_tgt = FIN_DB; end
      default:   m.issue = 1'b0;
    endcase
    return m;
  endfunction

  // saturate a finished sum to the delay word range
  function automatic logic signed [DELAY_BITS-1:0] sat_dly(
      input logic signed [SUM_W-1:0] v);
    logic all1;
    logic all0;
    logic signed [DELAY_BITS-1:0] r;
    all1 = &v[SUM_W-1:DELAY_BITS-1];
    all0 = ~|v[SUM_W-1:DELAY_BITS-1];
    if (all1 || all0) begin
      r = v[DELAY_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/cascaded_biquad_lowpass.sv
// Top level: two cascaded low-pass biquads on one shared multiplier.
// The sequencer walks its 24 steps per item; the result is then registered in the output register.
// A new item is accepted only when the sequencer is idle; the single shared multiplier does 20
// half-width partial products per item, two per coefficient product.
// A finished result waits in the output register; the last step stalls until it is taken.
// Reset (synchronous, rst_n low): delay words, coefficients and out_valid cleared.
`include "assert_macros.svh"

module cascaded_biquad_lowpass (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cbq_pkg::COEF_W-1:0]             cfg_data,
  // input item channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cbq_pkg::SAMPLE_BITS-1:0] in_sample_in,
  // result item channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_clipped
);

  localparam int SB = cbq_pkg::SAMPLE_BITS;
  localparam int DW = cbq_pkg::DELAY_BITS;
  localparam int BW = cbq_pkg::MUL_B_W;
  localparam int FW = cbq_pkg::FEED_W;
  localparam int CW = cbq_pkg::COEF_W;
  localparam int RW = cbq_pkg::RND_W;
  localparam int UW = cbq_pkg::SUM_W;

  // coefficient registers: feed unsigned Q1.30, feedback signed Q2.30
  logic [FW-1:0]        coef_feed_r;
  logic signed [CW-1:0] coef_back_one_r;
  logic signed [CW-1:0] coef_back_two_r;

  // per-section delay words, index 0 = first section
  logic signed [DW-1:0] dly_a_r [2];
  logic signed [DW-1:0] dly_b_r [2];

  logic signed [DW-1:0] xs_r;       // current section input
  logic signed [DW-1:0] y_r;        // current section output
  logic signed [SB-1:0] out_sample_r;
  logic                 out_clip_r;
  logic                 out_valid_r;

  cbq_pkg::ctrl_t       ctrl;
  logic                 idle;
  logic                 accept;
  logic signed [DW-1:0] operand;
  logic signed [BW-1:0] coef;
  logic signed [cbq_pkg::ACC_W-1:0] acc;
  logic signed [RW-1:0] rnd;
  logic signed [DW-1:0] fin_add;
  logic signed [UW-1:0] fin_sum;
  logic signed [DW-1:0] fin_val;
  logic                 y_hi_over;
  logic                 y_lo_over;
  logic signed [SB-1:0] y_sat;
  logic                 y_clip;

  assign in_ready = idle;
  assign accept   = in_valid && in_ready;

  cbq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_free (!out_valid_r || out_ready),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  // operand and coefficient muxes feeding the shared unit
  always_comb begin
    operand = ctrl.u.op_y ? y_r : xs_r;
    case (ctrl.u.coef_sel)
      cbq_pkg::CF_FEED:  coef = {{(BW-FW){1'b0}}, coef_feed_r};
      cbq_pkg::CF_FEED2: coef = {{(BW-FW-1){1'b0}}, coef_feed_r, 1'b0};
      cbq_pkg::CF_BACK1: coef = {coef_back_one_r[CW-1], coef_back_one_r};
      cbq_pkg::CF_BACK2: coef = {coef_back_two_r[CW-1], coef_back_two_r};
      default:           coef = '0;
    endcase
  end

  cbq_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .u       (ctrl.u),
    .operand (operand),
    .coef    (coef),
    .acc     (acc)
  );

  // finish: drop fraction bits (rounding bias already in acc), add delay, saturate
  always_comb begin
    rnd = acc[cbq_pkg::ACC_W-1:cbq_pkg::COEF_FRAC_BITS];
    case (ctrl.u.fin_tgt)
      cbq_pkg::FIN_Y:  fin_add = dly_a_r[ctrl.sec];
      cbq_pkg::FIN_DA: fin_add = dly_b_r[ctrl.sec];
      default:         fin_add = '0;
    endcase
    fin_sum = UW'(rnd) + UW'(fin_add);
    fin_val = cbq_pkg::sat_dly(fin_sum);
  end

  // final clamp to sample width
  always_comb begin
    y_hi_over = !y_r[DW-1] && (|y_r[DW-2:SB-1]);
    y_lo_over = y_r[DW-1] && !(&y_r[DW-2:SB-1]);
    y_clip    = y_hi_over || y_lo_over;
    if (y_hi_over) begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end else if (y_lo_over) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = y_r[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_feed_r     <= '0;
      coef_back_one_r <= '0;
      coef_back_two_r <= '0;
      dly_a_r[0]      <= '0;
      dly_a_r[1]      <= '0;
      dly_b_r[0]      <= '0;
      dly_b_r[1]      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cbq_pkg::REG_FEED:  coef_feed_r     <= cfg_data[FW-1:0];
          cbq_pkg::REG_BACK1: coef_back_one_r <= cfg_data;
          cbq_pkg::REG_BACK2: coef_back_two_r <= cfg_data;
          default:            ;  // unknown index ignored
        endcase
      end
      if (accept) begin
        xs_r <= {{(DW-SB){in_sample_in[SB-1]}}, in_sample_in};
      end else if (ctrl.sec_end) begin
        xs_r <= y_r;  // section two takes section one's result
      end
      if (ctrl.u.fin) begin
        case (ctrl.u.fin_tgt)
          cbq_pkg::FIN_Y:  y_r              <= fin_val;
          cbq_pkg::FIN_DA: dly_a_r[ctrl.sec] <= fin_val;
          cbq_pkg::FIN_DB: dly_b_r[ctrl.sec] <= fin_val;
          default:         ;
        endcase
      end
      if (ctrl.load_out) begin
        out_sample_r <= y_sat;
        out_clip_r   <= y_clip;
        out_valid_r  <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

  // an accepted item keeps the block busy in the following cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready)
  // the shared unit is quiet whenever the block is idle
  `ASSERT_IMPLIES(a_quiet_when_idle, clk, rst_n, in_ready, !ctrl.u.issue && !ctrl.u.fin)
  // a result is never loaded over one still waiting
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, ctrl.load_out, !out_valid_r || out_ready)

endmodule

FILE: rtl/cbq_mac.sv
// Shared multiply-accumulate unit: one half-operand product per cycle.
module cbq_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cbq_pkg::micro_t                     u,
  input  logic signed [cbq_pkg::DELAY_BITS-1:0] operand,
  input  logic signed [cbq_pkg::MUL_B_W-1:0]  coef,
  output logic signed [cbq_pkg::ACC_W-1:0]    acc
);

  localparam int DW = cbq_pkg::DELAY_BITS;
  localparam int HB = cbq_pkg::HALF_BITS;
  localparam int AW = cbq_pkg::MUL_A_W;
  localparam int CW = cbq_pkg::ACC_W;
  // accumulator starts at half an LSB so the final shift rounds half up
  localparam logic signed [CW-1:0] RND_HALF = CW'(1) << (cbq_pkg::COEF_FRAC_BITS - 1);

  logic signed [AW-1:0]              mul_a;
  logic signed [cbq_pkg::PROD_W-1:0] mul_r;
  logic                              tag_vld_r;
  logic                              tag_hi_r;
  logic                              tag_clr_r;
  logic signed [CW-1:0]              acc_r;
  logic signed [CW-1:0]              pext;
  logic signed [CW-1:0]              addend;

  always_comb begin
    if (u.hi) begin
      mul_a = {operand[DW-1], operand[DW-1:HB]};
    end else begin
      mul_a = {{(AW-HB){1'b0}}, operand[HB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= u.issue;
    end
    tag_hi_r  <= u.hi;
    tag_clr_r <= u.clr;
    mul_r     <= mul_a * coef;
  end

  always_comb begin
    pext = CW'(mul_r);
    if (tag_hi_r) begin
      pext = pext <<< HB;
    end
    addend = tag_clr_r ? RND_HALF : acc_r;
  end

  always_ff @(posedge clk) begin
    if (tag_vld_r) begin
      acc_r <= addend + pext;
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/cbq_seq.sv
// Step sequencer that walks both sections through the shared unit.
module cbq_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           out_free,
  output logic           idle,
  output cbq_pkg::ctrl_t ctrl
);

  localparam int SW = cbq_pkg::STEP_W;

  cbq_pkg::state_t  state_r, state_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic             sec;
  logic [SW-1:0]    ls_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbq_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign sec     = (step_r >= SW'(cbq_pkg::SEC_STEPS));
  assign ls_full = sec ? (step_r - SW'(cbq_pkg::SEC_STEPS)) : step_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ctrl          = '0;
    ctrl.u        = cbq_pkg::decode(4'(0));
    ctrl.u.issue  = 1'b0;
    ctrl.u.fin    = 1'b0;
    ctrl.u.clr    = 1'b0;
    ctrl.sec      = sec;
    case (state_r)
      cbq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = cbq_pkg::ST_RUN;
          step_nxt  = '0;
        end
      end
      cbq_pkg::ST_RUN: begin
        ctrl.u       = cbq_pkg::decode(ls_full[cbq_pkg::LS_W-1:0]);
        ctrl.sec_end = (step_r == SW'(cbq_pkg::SEC_STEPS - 1));
        if (step_r == SW'(cbq_pkg::TOTAL_STEPS - 1)) begin
          if (out_free) begin
            ctrl.load_out = 1'b1;
            state_nxt     = cbq_pkg::ST_IDLE;
          end else begin
            state_nxt = cbq_pkg::ST_HOLD;
          end
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      cbq_pkg::ST_HOLD: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = cbq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbq_pkg::ST_IDLE;
    endcase
  end

  assign idle = (state_r == cbq_pkg::ST_IDLE);

endmodule

FILE: dv/cascaded_biquad_lowpass_test.sv
// Self-checking testbench for the cascaded biquad low-pass filter.
`timescale 1ns / 100ps

module cascaded_biquad_lowpass_test;
  import cbq_pkg::*;

  // ---------------------------------------------------------------------
  // Types and constants
  // ---------------------------------------------------------------------
  localparam int WIDE_BITS = 80;  // holds any coef*value product sum exactly

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DELAY_BITS-1:0]  delay_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;
  typedef logic signed [COEF_W:0]        coef_ext_t;  // room for 2*a0

  typedef struct {
    sample_t value;
    logic    clip;
  } filtered_t;

  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam wide_t DLY_MAX   = (wide_t'(1) <<< (DELAY_BITS - 1)) - 1;
  localparam wide_t DLY_MIN   = -(wide_t'(1) <<< (DELAY_BITS - 1));
  localparam wide_t HALF_LSB  = wide_t'(1) <<< (COEF_FRAC_BITS - 1);

  // index 3 has no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  localparam real PI  = 3.141592653589793;
  localparam real Q30 = 1073741824.0;

  localparam int SETTLE_CYCLES    = 40;    // extra wait once every result has drained
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS     = 1450;
  localparam int LIMIT_NS         = 8000000;  // watchdog limit, in ns

  // ---------------------------------------------------------------------
  // DUT and clock
  // ---------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  sample_t              in_sample_in;
  logic                 out_valid;
  logic                 out_ready;
  sample_t              out_sample_out;
  logic                 out_clipped;

  cascaded_biquad_lowpass dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Filter predictor: coefficient copy and the four delay words
  // ---------------------------------------------------------------------
  logic [FEED_W-1:0]        feed_gain = '0;
  logic signed [COEF_W-1:0] back_one  = '0;
  logic signed [COEF_W-1:0] back_two  = '0;
  delay_t                   stage_a[2] = '{default: '0};
  delay_t                   stage_b[2] = '{default: '0};

  filtered_t expected_q[$];

  // run bookkeeping
  int mismatches     = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int clips_seen     = 0;
  int coef_sets      = 0;
  int burst_left     = 0;
  sample_t last_sample = '0;

  // long receiver hold: main bumps requests, the sink bumps served
  int long_hold_requests = 0;
  int long_hold_served   = 0;

  function automatic wide_t scaled_product(input delay_t v, input coef_ext_t c);
    wide_t vw;
    wide_t cw;
    vw = wide_t'(v);
    cw = wide_t'(c);
    return vw * cw;
  endfunction

  // round half up to the sample LSB (floor of sum + half)
  function automatic wide_t round_to_lsb(input wide_t acc);
    return (acc + HALF_LSB) >>> COEF_FRAC_BITS;
  endfunction

  function automatic delay_t rail_clamp(input wide_t v);
    if (v > DLY_MAX) return DLY_MAX[DELAY_BITS-1:0];
    if (v < DLY_MIN) return DLY_MIN[DELAY_BITS-1:0];
    return v[DELAY_BITS-1:0];
  endfunction

  // One transposed DF-II section; y feeds both feedback taps.
  task automatic filter_stage(input logic sec, input delay_t x, output delay_t y);
    coef_ext_t a0_c;
    coef_ext_t a0_twice;
    coef_ext_t b1_c;
    coef_ext_t b2_c;
    a0_c     = {2'b00, feed_gain};
    a0_twice = {1'b0, feed_gain, 1'b0};
    b1_c     = coef_ext_t'(back_one);
    b2_c     = coef_ext_t'(back_two);
    y = rail_clamp(stage_a[sec] + round_to_lsb(scaled_product(x, a0_c)));
    stage_a[sec] = rail_clamp(stage_b[sec] + round_to_lsb(scaled_product(x, a0_twice)
                                                         + scaled_product(y, b1_c)));
    stage_b[sec] = rail_clamp(round_to_lsb(scaled_product(x, a0_c)
                                           + scaled_product(y, b2_c)));
  endtask

  task automatic predict_filtered(input sample_t s, output filtered_t r);
    delay_t x;
    delay_t mid;
    delay_t y;
    x = delay_t'(s);
    filter_stage(1'b0, x, mid);
    filter_stage(1'b1, mid, y);
    r.clip = 1'b1;
    if (y > SMP_MAX) begin
      r.value = SMP_MAX;
    end else if (y < SMP_MIN) begin
      r.value = SMP_MIN;
    end else begin
      r.value = y[SAMPLE_BITS-1:0];
      r.clip  = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Configuration writes (block idle only)
  // ---------------------------------------------------------------------
  // Leaves cfg_we high; the caller lowers it after the last write so that
  // back-to-back writes never toggle it within one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_FEED:  feed_gain = data[FEED_W-1:0];
      REG_BACK1: back_one  = data;
      REG_BACK2: back_two  = data;
      default:   ;  // no register here
    endcase
    @(posedge clk);
  endtask

  task automatic load_coefs(input logic [31:0] feed, input logic [31:0] b1,
                            input logic [31:0] b2);
    write_reg(REG_FEED, feed);
    write_reg(REG_BACK1, b1);
    write_reg(REG_BACK2, b2);
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  // Coefficients as software would derive them for a given cutoff
  // (fraction of the sample rate) and resonance.
  task automatic derive_lowpass(input real cutoff, input real reso);
    real k;
    real norm;
    k    = $tan(PI * cutoff);
    norm = 1.0 + k / reso + k * k;
    load_coefs($rtoi(k * k / norm * Q30),
               $rtoi(2.0 * (1.0 - k * k) / norm * Q30),
               $rtoi(-(1.0 - k / reso + k * k) / norm * Q30));
  endtask

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h4000_0000;  // exactly 1.0
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts with random gaps; valid held until accepted
  // ---------------------------------------------------------------------
  task automatic push_sample(input sample_t s);
    filtered_t want;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    predict_filtered(s, want);
    expected_q.push_back(want);
    samples_sent++;
  endtask

  // stop offering, let every result drain, then wait out the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full-scale noise, with quiet stretches, held steps, rails and inversions
  function automatic sample_t next_sample(input sample_t prev);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return r[SAMPLE_BITS-1:0];
      4, 5:       return sample_t'($signed(r[12:0]));
      6, 7:       return prev;
      8:          return r[0] ? SMP_MAX : SMP_MIN;
      default:    return ~prev;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: own stall pattern, plus long holds on request
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int          hold_left;
    int          pattern_left;
    int          mode;
    logic [7:0]  pattern;
    hold_left    = 0;
    pattern_left = 0;
    mode         = 0;
    pattern      = 8'hFF;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_requests != long_hold_served) begin
        long_hold_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          mode         = $urandom_range(0, 3);
          pattern      = 8'($urandom) | 8'h01;
          pattern_left = $urandom_range(16, 200);
        end
        pattern_left--;
        case (mode)
          0:       out_ready <= 1'b1;                          // no stalls
          1:       out_ready <= pattern[pattern_left % 8];     // repeating mask
          2:       out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    filtered_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t MISMATCH unexpected item: expected none actual sample %0d clip %0b",
                 $time, out_sample_out, out_clipped);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        if (want.clip) clips_seen++;
        if (out_sample_out !== want.value) begin
          $display("%0t MISMATCH sample_out: expected %0d actual %0d",
                   $time, want.value, out_sample_out);
          mismatches++;
        end
        if (out_clipped !== want.clip) begin
          $display("%0t MISMATCH clipped: expected %0b actual %0b",
                   $time, want.clip, out_clipped);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // All coefficients at their reset value: everything filters to zero.
  task automatic test_reset_coefs();
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(24'h555555);
  endtask

  // Butterworth at a quarter of the sample rate, full-scale steps.
  task automatic test_stable_response();
    wait_idle();
    derive_lowpass(0.25, 0.7071);
    push_sample('0);
    push_sample(SMP_MAX);
    push_sample(SMP_MAX);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(SMP_MIN);
    push_sample(sample_t'(-1));
    push_sample(sample_t'(1));
  endtask

  // a0 near 2.0 (top bit of the data word is dropped): output clips.
  task automatic test_overdrive();
    wait_idle();
    load_coefs(32'hFFFF_FFFF, 32'h0, 32'h0);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(24'h400000);
    push_sample(sample_t'(1));
  endtask

  // Unstable feedback at both extremes: delay words ride the rails.
  task automatic test_unstable_rails();
    wait_idle();
    load_coefs(32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(SMP_MAX);
    push_sample(SMP_MAX);
    push_sample('0);
    push_sample('0);
    wait_idle();
    load_coefs(32'h4000_0000, 32'h8000_0000, 32'h8000_0000);
    push_sample(SMP_MIN);
    push_sample(SMP_MAX);
    push_sample('0);
    push_sample('0);
  endtask

  // A write to the empty index must leave the coefficients alone.
  task automatic test_unknown_index();
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    push_sample(24'h2AAAAA);
    push_sample(24'hD55555);
  endtask

  // Receiver holds off long enough for the block to back up its input.
  task automatic test_output_backpressure();
    wait_idle();
    derive_lowpass(0.05, 2.0);
    long_hold_requests++;
    repeat (20) begin
      last_sample = next_sample(last_sample);
      push_sample(last_sample);
    end
  endtask

  // Random coefficient sets, mostly realistic designs, some raw and extreme.
  task automatic test_random_settings();
    int random_sent;
    int batch;
    int pick;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 7);
      if (pick < 5) begin
        derive_lowpass($urandom_range(5, 4500) / 10000.0, $urandom_range(50, 800) / 100.0);
      end else if (pick == 5) begin
        load_coefs($urandom, $urandom, $urandom);
      end else begin
        load_coefs(extreme_word(), extreme_word(), extreme_word());
      end
      batch = $urandom_range(40, 160);
      repeat (batch) begin
        last_sample = next_sample(last_sample);
        push_sample(last_sample);
        random_sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_coefs();
    test_stable_response();
    test_overdrive();
    test_unstable_rails();
    test_unknown_index();
    test_output_backpressure();
    test_random_settings();
    wait_idle();

    $display("Filtered %0d samples across %0d coefficient sets, %0d results checked.",
             samples_sent, coef_sets, results_seen);
    $display("Saturated outputs: %0d; long output holds: %0d; mismatches: %0d.",
             clips_seen, long_hold_served, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cbq_pkg.sv
rtl/cbq_mac.sv
rtl/cbq_seq.sv
rtl/cascaded_biquad_lowpass.sv
dv/cascaded_biquad_lowpass_test.sv
